// ===== rtl/core/b64e_pkg.sv =====
package b64e_pkg;

   localparam int CharWidth = 7;
   localparam int SymWidth  = 6;
   localparam int MaxChars  = 4;

   localparam logic [CharWidth-1:0] PadChar = 7'd61;

   typedef logic [CharWidth-1:0] char_type;

   typedef struct packed {
      char_type [MaxChars-1:0] chars;
      logic [1:0]              count_m1;
      logic                    final_flag;
   } bundle_type;

   function automatic char_type sym(input logic [SymWidth-1:0] v);
      char_type ch;
      priority if (v < 6'd26) begin
         ch = char_type'(7'd65 + {1'b0, v});
      end else if (v < 6'd52) begin
         ch = char_type'(7'd71 + {1'b0, v});
      end else if (v < 6'd62) begin
         ch = char_type'({1'b0, v} - 7'd4);
      end else if (v == 6'd62) begin
         ch = 7'd43;
      end else begin
         ch = 7'd47;
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/b64e_front.sv =====
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                is_final,
   output b64e_pkg::bundle_type bundle
);

   localparam logic [1:0] PhaseFirst  = 2'd0;
   localparam logic [1:0] PhaseSecond = 2'd1;
   localparam logic [1:0] PhaseThird  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;

   always_comb begin
      bundle          = '0;
      bundle.chars[1] = b64e_pkg::PadChar;
      bundle.chars[2] = b64e_pkg::PadChar;
      bundle.chars[3] = b64e_pkg::PadChar;
      phase_in        = phase_ff;
      carry_in        = carry_ff;
      unique case (phase_ff)
         PhaseSecond: begin
            bundle.chars[0] = b64e_pkg::sym({carry_ff[1:0], data_byte[7:4]});
            if (is_final) begin
               bundle.chars[1]   = b64e_pkg::sym({data_byte[3:0], 2'b00});
               bundle.count_m1   = 2'd2;
               bundle.final_flag = 1'b1;
               phase_in          = PhaseFirst;
               carry_in          = '0;
            end else begin
               phase_in = PhaseThird;
               carry_in = data_byte[3:0];
            end
         end
         PhaseThird: begin
            bundle.chars[0]   = b64e_pkg::sym({carry_ff, data_byte[7:6]});
            bundle.chars[1]   = b64e_pkg::sym(data_byte[5:0]);
            bundle.count_m1   = 2'd1;
            bundle.final_flag = is_final;
            phase_in          = PhaseFirst;
            carry_in          = '0;
         end
         default: begin
            bundle.chars[0] = b64e_pkg::sym(data_byte[7:2]);
            if (is_final) begin
               bundle.chars[1]   = b64e_pkg::sym({data_byte[1:0], 4'b0000});
               bundle.count_m1   = 2'd3;
               bundle.final_flag = 1'b1;
               phase_in          = PhaseFirst;
               carry_in          = '0;
            end else begin
               phase_in = PhaseSecond;
               carry_in = {2'b00, data_byte[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseFirst;
         carry_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== rtl/core/b64e_queue.sv =====
module b64e_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64e_pkg::bundle_type push_data,
   input  logic                 pop,
   output b64e_pkg::bundle_type head,
   output logic                 full,
   output logic                 empty
);

   b64e_pkg::bundle_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== rtl/core/b64e_back.sv =====
module b64e_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64e_pkg::bundle_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output b64e_pkg::char_type   out_char,
   output logic                 out_last
);

   logic [1:0]         index_ff;
   logic               valid_ff;
   b64e_pkg::char_type char_ff;
   logic               last_ff;
   logic               load;
   logic               at_end;

   assign load      = !empty && (!valid_ff || out_ready);
   assign at_end    = (index_ff == head.count_m1);
   assign pop       = load && at_end;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            index_ff <= at_end ? 2'd0 : index_ff + 2'd1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head.chars[index_ff];
         last_ff <= at_end && head.final_flag;
      end
   end

endmodule

// ===== rtl/core/base64_stream_encoder.sv =====
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel req_*: one message byte per item, req_tlast on the last byte
// of a message. Output channel rsp_*: one ASCII character per item,
// rsp_tlast on the final character of the encoded message.
// Each byte yields one character, the third byte of a group two, and a
// final first or second byte also flushes the partial symbol and the '='
// pads (three or four characters in all).
// The first character of a byte is written to a queue entry and then
// loaded into the output register, which sends one character per cycle
// while rsp_tready is high; this sets the throughput.
// A two-entry queue of per-byte character groups sits between the byte
// front end and the character serializer, so bytes keep flowing while the
// receiver stalls until the queue fills; then req_tready drops.
// Reset (synchronous, active high) empties the queue and output register
// and returns to the start of a group.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // is_final
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast    // out_last
);

   b64e_pkg::bundle_type front_bundle;
   b64e_pkg::bundle_type queue_head;
   b64e_pkg::char_type   out_char;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 queue_pop;
   logic                 accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tdata  = {1'b0, out_char};

   b64e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .is_final  (req_tlast),
      .bundle    (front_bundle)
   );

   b64e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_bundle),
      .pop       (queue_pop),
      .head      (queue_head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .empty     (queue_empty),
      .pop       (queue_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (out_char),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== rtl/core/b64e_checker.sv =====
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'd65 && rsp_tdata <= 8'd90)
                  || (rsp_tdata >= 8'd97 && rsp_tdata <= 8'd122)
                  || (rsp_tdata >= 8'd48 && rsp_tdata <= 8'd57)
                  || rsp_tdata == 8'd43 || rsp_tdata == 8'd47 || rsp_tdata == 8'd61)
      else $error("rsp item outside base64 set");

   a_pad_then_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata == 8'd61 && !rsp_tlast
      |=> rsp_tvalid && rsp_tdata == 8'd61 && rsp_tlast)
      else $error("first of two pads not followed by final pad");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/tb_base64_stream_encoder.sv =====
module tb_base64_stream_encoder;

   localparam int CycleLimit     = 200000;
   localparam int MaxShownErrors = 10;
   localparam int DrainCycles    = 16;
   localparam int PhaseItems     = 56;

   localparam logic [1:0] GroupFirst  = 2'd0;
   localparam logic [1:0] GroupSecond = 2'd1;
   localparam logic [1:0] GroupThird  = 2'd2;

   localparam logic [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } msg_byte_type;

   typedef struct packed {
      b64e_pkg::char_type ch;
      logic               last;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] data_byte
   logic       req_tlast = 1'b0;   // is_final
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [6:0] out_char, [7] zero
   logic       rsp_tlast;          // out_last

   msg_byte_type pending_bytes[$];
   enc_char_type expected_chars[$];
   msg_byte_type next_byte;
   enc_char_type want_char;
   logic         req_fire = 1'b0;
   logic [1:0]   enc_phase = GroupFirst;
   logic [3:0]   enc_carry = 4'd0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           error_count = 0;
   int           cycle_count = 0;

   base64_stream_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic b64e_pkg::char_type b64_char(input logic [5:0] v);
      return b64e_pkg::char_type'(Alphabet[8*(63-int'(v)) +: 8]);
   endfunction

   function void push_char(input b64e_pkg::char_type ch, input logic last);
      enc_char_type item;
      item.ch   = ch;
      item.last = last;
      expected_chars.insert(expected_chars.size(), item);
   endfunction

   function void encode_byte(input logic [7:0] b, input logic fin);
      case (enc_phase)
         GroupSecond: begin
            push_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               push_char(b64_char({b[3:0], 2'b00}), 1'b0);
               push_char(b64e_pkg::PadChar, 1'b1);
               enc_phase = GroupFirst;
               enc_carry = 4'd0;
            end else begin
               enc_phase = GroupThird;
               enc_carry = b[3:0];
            end
         end
         GroupThird: begin
            push_char(b64_char({enc_carry, b[7:6]}), 1'b0);
            push_char(b64_char(b[5:0]), fin);
            enc_phase = GroupFirst;
            enc_carry = 4'd0;
         end
         default: begin
            push_char(b64_char(b[7:2]), 1'b0);
            if (fin) begin
               push_char(b64_char({b[1:0], 4'b0000}), 1'b0);
               push_char(b64e_pkg::PadChar, 1'b0);
               push_char(b64e_pkg::PadChar, 1'b1);
               enc_phase = GroupFirst;
               enc_carry = 4'd0;
            end else begin
               enc_phase = GroupSecond;
               enc_carry = {2'b00, b[1:0]};
            end
         end
      endcase
   endfunction

   function void queue_byte(input logic [7:0] b, input logic fin);
      msg_byte_type item;
      item.data = b;
      item.fin  = fin;
      pending_bytes.insert(pending_bytes.size(), item);
   endfunction

   function int queue_message();
      int len;
      if ($urandom_range(9) == 0) begin
         len = $urandom_range(8, 20);
      end else begin
         len = $urandom_range(1, 7);
      end
      for (int i = 0; i < len; i++) begin
         queue_byte(8'($urandom), i == len - 1);
      end
      return len;
   endfunction

   task automatic wait_drain();
      do begin
         @(posedge clock);
      end while (pending_bytes.size() != 0 || req_tvalid || expected_chars.size() != 0);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data;
               req_tlast  <= next_byte.fin;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               if (error_count <= MaxShownErrors) begin
                  $display("unexpected char: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
               end
            end else begin
               want_char = expected_chars.pop_front();
               if (rsp_tdata !== {1'b0, want_char.ch} || rsp_tlast !== want_char.last) begin
                  error_count++;
                  if (error_count <= MaxShownErrors) begin
                     $display("char mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                              {1'b0, want_char.ch}, want_char.last, rsp_tdata, rsp_tlast);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int added;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_byte(8'h00, 1'b1);
      queue_byte(8'hff, 1'b1);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'hfb, 1'b0);
      queue_byte(8'hef, 1'b0);
      queue_byte(8'hbe, 1'b0);
      queue_byte(8'hff, 1'b1);
      queue_byte(8'h4d, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6e, 1'b0);
      queue_byte(8'h4d, 1'b0);
      queue_byte(8'h61, 1'b1);
      queue_byte(8'haa, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'h01, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 68;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 68;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct = 13;
            end
         endcase
         added = 0;
         while (added < PhaseItems) begin
            added += queue_message();
         end
         wait_drain();
      end

      repeat (DrainCycles) @(posedge clock);
      error_count += expected_chars.size();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
